@@ sv/mnso_pkg.sv @@
// mnso_pkg: shared types, constants and elaboration-time table functions
// for the midi note sine oscillator. No dependencies.

package mnso_pkg;

  localparam int SAMPLE_RATE_DEF     = 48000;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [63:0] REF_FREQ_HZ = 64'd440;
  localparam logic [63:0] COEF_A1     = 64'd1686629713;
  localparam logic [63:0] COEF_A3     = 64'd693598669;
  localparam logic [63:0] COEF_A5     = 64'd85569306;
  localparam logic [63:0] COEF_A7     = 64'd5026995;
  localparam logic [63:0] COEF_A9     = 64'd172272;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;

  typedef struct packed {
    logic        kind;
    logic [6:0]  note_number;
    logic [15:0] duration_ms;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_end;
    logic               idle;
  } smp_t;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [23:0] samples_left;
  } note_cfg_t;

  // semitone ratios 2^(k/12) in q16
  function automatic logic [63:0] semitone_q16(input int unsigned k);
    logic [63:0] r;
    unique case (k)
      0:  r = 64'd65536;
      1:  r = 64'd69433;
      2:  r = 64'd73562;
      3:  r = 64'd77936;
      4:  r = 64'd82570;
      5:  r = 64'd87480;
      6:  r = 64'd92682;
      7:  r = 64'd98193;
      8:  r = 64'd104032;
      9:  r = 64'd110218;
      10: r = 64'd116772;
      default: r = 64'd123715;
    endcase
    return r;
  endfunction

  // quarter-wave magnitude, odd degree-9 polynomial in q30
  function automatic logic [15:0] quarter_mag(input int unsigned pos, input int unsigned qbits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] mag;
    u   = 64'(pos) << (30 - qbits);
    u2  = (u * u) >> 30;
    p   = COEF_A9;
    p   = COEF_A7 - ((p * u2) >> 30);
    p   = COEF_A5 - ((p * u2) >> 30);
    p   = COEF_A3 - ((p * u2) >> 30);
    p   = COEF_A1 - ((p * u2) >> 30);
    s   = (p * u) >> 30;
    mag = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    return mag[15:0];
  endfunction

endpackage

@@ sv/mnso_note_setup.sv @@
// mnso_note_setup: phase step table and sample budget for a start-note beat.
// Depends on mnso_pkg.

module mnso_note_setup import mnso_pkg::*; #(
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic [6:0]  note_number,
  input  logic [15:0] duration_ms,
  output note_cfg_t   cfg
);

  localparam int FRAC_SHIFT = 27;
  localparam logic [23:0] RATE_KHZ = 24'(SAMPLE_RATE / 1000);
  localparam logic [63:0] RATE_REM = 64'(SAMPLE_RATE % 1000);
  localparam logic [63:0] RECIP =
    ((RATE_REM << FRAC_SHIFT) + 64'd999) / 64'd1000;

  logic [31:0] step_rom [128];

  for (genvar i = 0; i < 128; i++) begin : g_step
    localparam int T   = i + 3;
    localparam int OCT = T / 12;
    localparam int K   = T % 12;
    localparam logic [63:0] SCALED = (REF_FREQ_HZ * semitone_q16(K)) << (10 + OCT);
    localparam logic [63:0] STEP =
      (SCALED + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
    assign step_rom[i] = STEP[31:0];
  end

  logic [23:0] whole_part;
  logic [42:0] frac_prod;

  // budget = dur*khz + dur*rem/1000, the second by a rounded-up fixed-point reciprocal
  assign whole_part = 24'(duration_ms) * RATE_KHZ;
  assign frac_prod  = 43'(duration_ms) * RECIP[FRAC_SHIFT-1:0];

  assign cfg.phase_step   = step_rom[note_number];
  assign cfg.samples_left = whole_part + 24'(frac_prod[42:FRAC_SHIFT]);

endmodule

@@ sv/mnso_sine_rom.sv @@
// mnso_sine_rom: quarter-wave sine table with registered read and sign fold.
// Depends on mnso_pkg.

module mnso_sine_rom import mnso_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-1:0] index,
  output logic signed [15:0]         sample
);

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int DEPTH = (1 << QBITS) + 1;
  localparam logic [QBITS:0] QUARTER = (QBITS + 1)'(1) << QBITS;

  logic [15:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = quarter_mag(i, QBITS);
  end

  logic [1:0]     quad;
  logic [QBITS:0] rest;
  logic [QBITS:0] pos;
  logic [15:0]    mag;
  logic           negate;

  assign quad = index[SINE_TABLE_BITS-1 -: 2];
  assign rest = {1'b0, index[QBITS-1:0]};
  assign pos  = quad[0] ? (QUARTER - rest) : rest;

  always_ff @(posedge clk) begin
    mag    <= rom[pos];
    negate <= quad[1];
  end

  assign sample = $signed(negate ? (16'd0 - mag) : mag);

endmodule

@@ sv/midi_note_sine_oscillator.sv @@
// midi_note_sine_oscillator: top level, phase/step/budget state and beat control.
// Depends on mnso_pkg, mnso_note_setup and mnso_sine_rom.
// A tick's beat waits in the stage register, then its result is registered.
// Throughput: one beat per cycle unless smp_stall holds a tick; the sine table
// is read at the next phase, so state update and table read share each cycle.
// Reset clears phase, step, sample budget and both valid flags; no sweep needed.

module midi_note_sine_oscillator import mnso_pkg::*; #(
  parameter int SAMPLE_RATE     = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic smp_valid,
  input  logic smp_stall,
  output smp_t smp
);

  logic        stage_valid;
  cmd_t        stage;
  logic [31:0] phase;
  logic [31:0] phase_next;
  logic [31:0] phase_step;
  logic [23:0] samples_left;
  logic        is_tick;
  logic        done;
  logic        take;
  logic        active;
  note_cfg_t   note_cfg;
  logic signed [15:0] sine;

  mnso_note_setup #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_setup (
    .note_number(stage.note_number),
    .duration_ms(stage.duration_ms),
    .cfg        (note_cfg)
  );

  mnso_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .index (phase_next[31 -: SINE_TABLE_BITS]),
    .sample(sine)
  );

  assign is_tick   = (stage.kind == KIND_TICK);
  assign active    = (samples_left != 24'd0);
  assign done      = stage_valid && (!is_tick || !smp_valid || !smp_stall);
  assign cmd_stall = stage_valid && !done;
  assign take      = cmd_valid && !cmd_stall;

  always_comb begin
    phase_next = phase;
    if (rst) begin
      phase_next = 32'd0;
    end else if (done && is_tick && active) begin
      phase_next = phase + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      smp_valid    <= 1'b0;
      phase        <= 32'd0;
      phase_step   <= 32'd0;
      samples_left <= 24'd0;
    end else begin
      phase <= phase_next;
      if (take) begin
        stage_valid <= 1'b1;
      end else if (done) begin
        stage_valid <= 1'b0;
      end
      if (done && is_tick) begin
        smp_valid <= 1'b1;
      end else if (!smp_stall) begin
        smp_valid <= 1'b0;
      end
      if (done) begin
        if (!is_tick) begin
          phase_step   <= note_cfg.phase_step;
          samples_left <= note_cfg.samples_left;
        end else if (active) begin
          samples_left <= samples_left - 24'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      stage <= cmd;
    end
    if (done && is_tick) begin
      smp.sample   <= sine;
      smp.note_end <= (samples_left == 24'd1);
      smp.idle     <= !active;
    end
  end

endmodule
